@@ sv/rqbf_pkg.sv @@
// Package for the radius query block: beat payload types, command and status
// structs between controller and datapath, and the function codes.
// No dependencies.
package rqbf_pkg;

    localparam int COORD_W   = 24;
    localparam int ID_W      = 24;
    localparam int RADIUS_W  = 23;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 2;
    localparam int BOX_W     = COORD_W + 2;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int SUM_W     = SQ_W + 1;
    localparam int R2_W      = 2 * RADIUS_W;

    localparam logic [PADDR_W-1:0] REG_RADIUS = 2'd0;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [1:0]       func;
        t_coord           coord_x;
        t_coord           coord_y;
        t_coord           coord_z;
        logic [ID_W-1:0]  point_id;
        logic             last_query;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  result_id;
        logic             within_res;
        logic             batch_end;
    } t_out_item;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic clear;
        logic load;
        logic query;
        logic scan_start;
        logic scan_step;
        logic flush;
        logic res_load;
        logic res_hit;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic scan_more;
        logic hit;
        logic busy;
    } t_status;

endpackage

@@ sv/rqbf_ctrl.sv @@
// Controller of the radius query block: sequences clear, load and query
// beats and drives the datapath through t_cmd. Depends on rqbf_pkg.
module rqbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rqbf_pkg::t_status i_status,
    output rqbf_pkg::t_cmd    o_cmd
);
    import rqbf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_hit;
    logic   r_out_valid;
    logic   in_acc;
    logic   res_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign res_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.clear      = (i_func == FUNC_CLEAR);
                    o_cmd.load       = (i_func == FUNC_LOAD);
                    o_cmd.query      = (i_func == FUNC_QUERY);
                    o_cmd.scan_start = (i_func == FUNC_QUERY);
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.flush = 1'b1;
                end else begin
                    o_cmd.scan_step = i_status.scan_more;
                end
            end
            ST_DONE: begin
                o_cmd.res_load = res_free;
                o_cmd.res_hit  = r_hit;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && res_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_func == FUNC_QUERY) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_hit <= 1'b0;
                    if (i_status.in_range) begin
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (i_status.hit) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_DONE;
                    end else if (!i_status.scan_more && !i_status.busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/rqbf_dp.sv @@
// Datapath of the radius query block: target memory, bounding box, scan
// counter and the squared-distance pipeline. Depends on rqbf_pkg.
module rqbf_dp #(
    parameter int MAX_TARGETS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rqbf_pkg::t_cmd                i_cmd,
    input  rqbf_pkg::t_in_item            i_item,
    input  logic [rqbf_pkg::RADIUS_W-1:0] i_radius,
    output rqbf_pkg::t_status             o_status,
    output rqbf_pkg::t_out_item           o_result
);
    import rqbf_pkg::*;

    localparam int CW = $clog2(MAX_TARGETS + 1);
    localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    t_point             mem [MAX_TARGETS];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    t_coord             r_box_lo [3];
    t_coord             r_box_hi [3];
    t_coord             r_q [3];
    logic [ID_W-1:0]    r_q_id;
    logic               r_q_last;
    logic [R2_W-1:0]    r_r2;
    t_point             r_rd;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [DIFF_W-1:0]  r_ad [3];
    logic [SQ_W-1:0]    r_sq [3];
    t_out_item          r_res;

    t_coord             p_in [3];
    t_coord             p_rd [3];
    logic               full;
    logic               in_box [3];
    logic [SUM_W-1:0]   sum;
    logic               le;

    assign p_in[0] = i_item.coord_x;
    assign p_in[1] = i_item.coord_y;
    assign p_in[2] = i_item.coord_z;
    assign p_rd[0] = r_rd.x;
    assign p_rd[1] = r_rd.y;
    assign p_rd[2] = r_rd.z;

    assign full = (r_count == CW'(MAX_TARGETS));

    // Query must lie inside the bounding box grown by the radius on each side.
    always_comb begin
        logic signed [BOX_W-1:0] lo;
        logic signed [BOX_W-1:0] hi;
        logic signed [BOX_W-1:0] p;
        logic signed [BOX_W-1:0] r;
        r = $signed({3'b000, i_radius});
        for (int k = 0; k < 3; k++) begin
            lo        = BOX_W'(r_box_lo[k]) - r;
            hi        = BOX_W'(r_box_hi[k]) + r;
            p         = BOX_W'(r_q[k]);
            in_box[k] = (p >= lo) && (p <= hi);
        end
    end

    assign sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign le  = (sum <= SUM_W'(r_r2));

    assign o_status.in_range  = in_box[0] && in_box[1] && in_box[2];
    assign o_status.scan_more = (r_idx < r_count);
    assign o_status.hit       = r_v3 && le;
    assign o_status.busy      = r_v1 || r_v2 || r_v3;
    assign o_result           = r_res;

    // Target memory: one write port for loads, one registered read for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem[r_count[AW-1:0]] <= '{x: i_item.coord_x, y: i_item.coord_y,
                                      z: i_item.coord_z};
        end
        if (i_cmd.scan_step) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_box_lo[k] <= COORD_MAX;
                r_box_hi[k] <= COORD_MIN;
            end
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_box_lo[k] <= COORD_MAX;
                    r_box_hi[k] <= COORD_MIN;
                end
            end else if (i_cmd.load && !full) begin
                r_count <= r_count + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (p_in[k] < r_box_lo[k]) begin
                        r_box_lo[k] <= p_in[k];
                    end
                    if (p_in[k] > r_box_hi[k]) begin
                        r_box_hi[k] <= p_in[k];
                    end
                end
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.flush) begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
            end else begin
                r_v1 <= i_cmd.scan_step;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [DIFF_W-1:0] d;
        r_r2 <= i_radius * i_radius;
        if (i_cmd.query) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= p_in[k];
            end
            r_q_id   <= i_item.point_id;
            r_q_last <= i_item.last_query;
        end
        for (int k = 0; k < 3; k++) begin
            d         = DIFF_W'(r_q[k]) - DIFF_W'(p_rd[k]);
            r_ad[k]   <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            r_sq[k]   <= SQ_W'(r_ad[k] * r_ad[k]);
        end
        if (i_cmd.res_load) begin
            r_res.result_id  <= r_q_id;
            r_res.within_res <= i_cmd.res_hit;
            r_res.batch_end  <= r_q_last;
        end
    end

endmodule

@@ sv/radius_query_brute_force.sv @@
// Top level of the radius query block: APB radius register and the
// controller and datapath instances. Depends on rqbf_pkg, rqbf_ctrl, rqbf_dp.
//
// Input beats carry a function code: clear empties the target set, load
// appends a target point, query asks whether any target lies within the
// radius. Clear and load beats give no result. A query gives exactly one
// output beat with its id, a hit flag and the batch mark. A query outside
// the bounding box grown by the radius goes from its check state straight
// to the done state. Otherwise the targets are read from memory one per
// cycle through a three-stage distance pipeline, limited by the single read
// port of the target memory; the scan stops at the first target found
// within the radius. One query is worked on at a time. The finished result
// sits in an output register, so the next beat is taken while it waits; if
// the receiver still stalls when the next query is done, that query holds
// until the register frees. Loads beyond MAX_TARGETS are dropped.
// Reset empties the set, clears the radius to zero and drops any result.
// The radius is written through the APB port at address 0; the user must
// write it only while idle, which the block itself does not enforce.
module radius_query_brute_force #(
    parameter int MAX_TARGETS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rqbf_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output rqbf_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rqbf_pkg::PADDR_W-1:0] paddr,
    input  logic [rqbf_pkg::APB_W-1:0]   pwdata,
    output logic [rqbf_pkg::APB_W-1:0]   prdata,
    output logic                         pready
);
    import rqbf_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    t_cmd                cmd;
    t_status             status;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RADIUS) ? APB_W'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (psel && penable && pwrite && paddr == REG_RADIUS) begin
            r_radius <= pwdata[RADIUS_W-1:0];
        end
    end

    rqbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_data.func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rqbf_dp #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_data),
        .i_radius (r_radius),
        .o_status (status),
        .o_result (o_out_data)
    );

endmodule
